/* rtl/gbh_pkg.sv */
// Package: item types, status codes, CSR indices, controller states and divider request for the histogram.
package gbh_pkg;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] value;
      logic signed [31:0] second_value;
      logic [11:0]        read_bin;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [11:0]        bin_number;
      logic [31:0]        bin_count;
      logic [16:0]        bin_fraction;
      logic signed [31:0] second_mean;
   } rsp_type;

   typedef struct packed {
      logic [31:0] rem_init;
      logic [63:0] dividend;
      logic [31:0] divisor;
      logic [6:0]  steps;
   } div_req_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_READ,
      S_UPDATE,
      S_MEAN_GO,
      S_MEAN,
      S_FRAC_GO,
      S_FRAC,
      S_RESP
   } state_type;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_RANGE      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd2;

   localparam logic [1:0] CSR_LOWER_BOUND = 2'd0;
   localparam logic [1:0] CSR_FIRST_WIDTH = 2'd1;
   localparam logic [1:0] CSR_GROWTH      = 2'd2;
   localparam logic [1:0] CSR_NORM_TOTAL  = 2'd3;

   localparam logic [6:0] MEAN_STEPS = 7'd64;
   localparam logic [6:0] FRAC_STEPS = 7'd16;

   localparam logic [33:0] WIDTH_CAP = 34'h2_0000_0000;
   localparam logic [16:0] FRAC_ONE  = 17'h1_0000;

endpackage

/* rtl/geometric_bin_histogram_core.sv */
// Top level: histogram controller with bin store, bin search and shared divider.
// One item at a time; busy is high from acceptance until the result strobe. After reset a
// clearing pass empties the bin store with busy high. A read item reads its bin, then runs
// the mean division, skipped when the bin is empty, and the fraction division, skipped when
// the fraction needs no division. A sample first walks the bin edges, then updates its bin
// and goes on as a read; a value beyond the last bin ends the walk with a range status. The
// 64-step mean division and 16-step fraction division share one divider.
// Each result on rsp_data is flagged by rsp_strobe for a single cycle and cannot be stalled.
module geometric_bin_histogram_core #(
   parameter int BINS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gbh_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gbh_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import gbh_pkg::*;

   localparam int ADDR_W = $clog2(BINS);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic signed [31:0] lb_ff;
   logic [30:0]        fw_ff;
   logic [15:0]        gr_ff;
   logic [31:0]        nt_ff;
   req_type            item_ff, item_in;
   logic [1:0]         status_ff, status_in;
   logic [11:0]        binno_ff, binno_in;
   logic [31:0]        cnt_ff, cnt_in;
   logic signed [63:0] sum_ff, sum_in;
   logic [16:0]        frac_ff, frac_in;
   logic signed [31:0] mean_ff, mean_in;
   logic [31:0]        seen_ff, seen_in;
   logic               neg_ff, neg_in;

   logic               accept;
   logic               rb_range;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [95:0]        ram_wdata;
   logic [95:0]        ram_rdata;
   logic               walk_go;
   logic               walk_done;
   logic               walk_over;
   logic [ADDR_W-1:0]  walk_bin;
   logic               div_start;
   div_req_type        div_req;
   logic               div_done;
   logic [63:0]        div_quo;
   logic [31:0]        rd_cnt;
   logic signed [63:0] rd_sum;
   logic [64:0]        sum_ext;
   logic [31:0]        divisor;
   logic [63:0]        sum_mag;

   gbh_ram #(.WIDTH(96), .DEPTH(BINS)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   gbh_walk #(.BINS(BINS)) u_walk (
      .clock       (clock),
      .reset       (reset),
      .start       (walk_go),
      .value       (req_data.value),
      .lower_bound (lb_ff),
      .first_width (fw_ff),
      .growth      (gr_ff),
      .done        (walk_done),
      .over        (walk_over),
      .bin         (walk_bin)
   );

   gbh_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .req   (div_req),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign accept    = start && !busy;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;
   assign rb_range  = 32'(req_data.read_bin) >= 32'(BINS);
   assign rd_cnt    = ram_rdata[31:0];
   assign rd_sum    = ram_rdata[95:32];
   assign sum_ext   = 65'(rd_sum) + 65'(item_ff.second_value);
   assign divisor   = (nt_ff != 32'd0) ? nt_ff : seen_ff;
   assign sum_mag   = sum_ff[63] ? 64'(-sum_ff) : sum_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(BINS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_data.mode) begin
                  state_in = rb_range ? S_RESP : S_READ;
               end else begin
                  state_in = (fw_ff == 31'd0) ? S_RESP : S_WALK;
               end
            end
         end
         S_WALK: begin
            if (walk_done) state_in = walk_over ? S_RESP : S_READ;
         end
         S_READ:    state_in = S_UPDATE;
         S_UPDATE:  state_in = S_MEAN_GO;
         S_MEAN_GO: state_in = (cnt_ff == 32'd0) ? S_FRAC_GO : S_MEAN;
         S_MEAN: begin
            if (div_done) state_in = S_FRAC_GO;
         end
         S_FRAC_GO: begin
            state_in = (divisor == 32'd0 || cnt_ff >= divisor) ? S_RESP : S_FRAC;
         end
         S_FRAC: begin
            if (div_done) state_in = S_RESP;
         end
         S_RESP:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      clr_in     = clr_ff;
      addr_in    = addr_ff;
      item_in    = item_ff;
      status_in  = status_ff;
      binno_in   = binno_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      frac_in    = frac_ff;
      mean_in    = mean_ff;
      seen_in    = seen_ff;
      neg_in     = neg_ff;
      ram_we     = 1'b0;
      ram_waddr  = addr_ff;
      ram_wdata  = {sum_ff, cnt_ff};
      walk_go    = 1'b0;
      div_start  = 1'b0;
      div_req    = '{rem_init: 32'd0, dividend: sum_mag, divisor: cnt_ff, steps: MEAN_STEPS};
      rsp_strobe = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               item_in   = req_data;
               status_in = STATUS_OK;
               binno_in  = '0;
               cnt_in    = '0;
               sum_in    = '0;
               frac_in   = '0;
               mean_in   = '0;
               addr_in   = ADDR_W'(req_data.read_bin);
               if (req_data.mode) begin
                  binno_in = req_data.read_bin;
                  if (rb_range) status_in = STATUS_RANGE;
               end else if (fw_ff == 31'd0) begin
                  status_in = STATUS_ZERO_WIDTH;
               end else begin
                  walk_go = 1'b1;
               end
            end
         end
         S_WALK: begin
            if (walk_done) begin
               if (walk_over) begin
                  status_in = STATUS_RANGE;
               end else begin
                  addr_in  = walk_bin;
                  binno_in = 12'(walk_bin);
               end
            end
         end
         S_READ: begin
         end
         S_UPDATE: begin
            cnt_in = rd_cnt;
            sum_in = rd_sum;
            if (!item_ff.mode) begin
               if (rd_cnt != 32'hFFFF_FFFF) begin
                  cnt_in = rd_cnt + 32'd1;
                  if (sum_ext[64] != sum_ext[63]) begin
                     sum_in = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                  end else begin
                     sum_in = sum_ext[63:0];
                  end
                  ram_we    = 1'b1;
                  ram_wdata = {sum_in, cnt_in};
               end
               if (seen_ff != 32'hFFFF_FFFF) seen_in = seen_ff + 32'd1;
            end
         end
         S_MEAN_GO: begin
            neg_in = sum_ff[63];
            if (cnt_ff != 32'd0) div_start = 1'b1;
         end
         S_MEAN: begin
            if (div_done) begin
               if (neg_ff) begin
                  mean_in = (div_quo > 64'h8000_0000) ? 32'sh8000_0000
                                                      : 32'(-div_quo[31:0]);
               end else begin
                  mean_in = (div_quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_quo[31:0];
               end
            end
         end
         S_FRAC_GO: begin
            div_req = '{rem_init: cnt_ff, dividend: 64'd0, divisor: divisor, steps: FRAC_STEPS};
            if (divisor == 32'd0) begin
               frac_in = '0;
            end else if (cnt_ff >= divisor) begin
               frac_in = FRAC_ONE;
            end else begin
               div_start = 1'b1;
            end
         end
         S_FRAC: begin
            if (div_done) frac_in = {1'b0, div_quo[15:0]};
         end
         S_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         seen_ff  <= '0;
         lb_ff    <= '0;
         fw_ff    <= 31'd65536;
         gr_ff    <= 16'd256;
         nt_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         seen_ff  <= seen_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LOWER_BOUND: lb_ff <= csr_data;
               CSR_FIRST_WIDTH: fw_ff <= csr_data[30:0];
               CSR_GROWTH:      gr_ff <= csr_data[15:0];
               CSR_NORM_TOTAL:  nt_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
      addr_ff   <= addr_in;
      item_ff   <= item_in;
      status_ff <= status_in;
      binno_ff  <= binno_in;
      cnt_ff    <= cnt_in;
      sum_ff    <= sum_in;
      frac_ff   <= frac_in;
      mean_ff   <= mean_in;
      neg_ff    <= neg_in;
   end

   assign rsp_data = '{status: status_ff, bin_number: binno_ff, bin_count: cnt_ff,
                       bin_fraction: frac_ff, second_mean: mean_ff};

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy && !rsp_strobe)
      else $error("result strobe not followed by idle");
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || (state_ff == S_UPDATE && !item_ff.mode)))
      else $error("store written outside clear or sample update");
   a_frac_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> frac_ff <= FRAC_ONE)
      else $error("fraction above one");
`endif
endmodule

/* rtl/gbh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gbh_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/gbh_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module gbh_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  gbh_pkg::div_req_type req,
   output logic                done,
   output logic [63:0]         quo
);
   import gbh_pkg::*;

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [6:0]  left_ff, left_in;
   logic [31:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[63]};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      ge      = rem_sh >= {1'b0, dsr_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      left_in = left_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         run_in  = 1'b1;
         left_in = req.steps;
         rem_in  = req.rem_init;
         dvd_in  = req.dividend;
         dsr_in  = req.divisor;
         quo_in  = '0;
      end else if (run_ff) begin
         rem_in  = ge ? rem_sub[31:0] : rem_sh[31:0];
         dvd_in  = {dvd_ff[62:0], 1'b0};
         quo_in  = {quo_ff[62:0], ge};
         left_in = left_ff - 7'd1;
         if (left_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         left_ff <= left_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

/* rtl/gbh_walk.sv */
// Bin search: walks geometric bin edges upward, one edge per cycle.
module gbh_walk #(
   parameter int BINS = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [31:0]      value,
   input  logic signed [31:0]      lower_bound,
   input  logic [30:0]             first_width,
   input  logic [15:0]             growth,
   output logic                    done,
   output logic                    over,
   output logic [$clog2(BINS)-1:0] bin
);
   import gbh_pkg::*;

   localparam int ADDR_W = $clog2(BINS);
   localparam int CNT_W  = $clog2(BINS + 1);

   logic                     run_ff, run_in;
   logic                     done_ff, done_in;
   logic                     over_ff, over_in;
   logic [ADDR_W-1:0]        bin_ff, bin_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic signed [63:0]       edge_ff, edge_in;
   logic [33:0]              w_ff, w_in;
   logic signed [31:0]       x_ff, x_in;
   logic [15:0]              g_ff, g_in;
   logic [49:0]              prod;
   logic [41:0]              next_w;

   always_comb begin
      prod    = w_ff * g_ff;
      next_w  = prod[49:8];
      run_in  = run_ff;
      done_in = 1'b0;
      over_in = over_ff;
      bin_in  = bin_ff;
      idx_in  = idx_ff;
      edge_in = edge_ff;
      w_in    = w_ff;
      x_in    = x_ff;
      g_in    = g_ff;
      if (start) begin
         run_in  = 1'b1;
         idx_in  = '0;
         edge_in = 64'(lower_bound);
         w_in    = {3'b000, first_width};
         x_in    = value;
         g_in    = growth;
      end else if (run_ff) begin
         if (idx_ff == CNT_W'(BINS)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            over_in = 1'b1;
         end else if (64'(x_ff) > edge_ff) begin
            edge_in = edge_ff + $signed({30'b0, w_ff});
            w_in    = (next_w > 42'(WIDTH_CAP)) ? WIDTH_CAP : next_w[33:0];
            idx_in  = idx_ff + CNT_W'(1);
         end else begin
            run_in  = 1'b0;
            done_in = 1'b1;
            over_in = 1'b0;
            bin_in  = idx_ff[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      over_ff <= over_in;
      bin_ff  <= bin_in;
      idx_ff  <= idx_in;
      edge_ff <= edge_in;
      w_ff    <= w_in;
      x_ff    <= x_in;
      g_ff    <= g_in;
   end

   assign done = done_ff;
   assign over = over_ff;
   assign bin  = bin_ff;
endmodule
